// ===== sv/y2p_pkg.sv =====
// ----------------------------------------------------------------------------
// y2p_pkg
// Shared widths, register codes and the stage record of the YUYV to planar
// YUV 4:2:0 converter.
// ----------------------------------------------------------------------------
package y2p_pkg;

    // Field widths.
    localparam int PIX_W     = 8;
    localparam int LUMA_AW   = 20;
    localparam int CHROMA_AW = 21;
    localparam int CIDX_W    = 18;
    localparam int CFG_DW    = 11;
    localparam int CFG_IW    = 2;
    localparam int PLANE_W   = CHROMA_AW + 2;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IW-1:0] REG_SWAP_CHROMA  = 2'd2;

    // Register values after reset.
    localparam logic [CFG_DW-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [CFG_DW-1:0] RST_FRAME_HEIGHT = 11'd480;

    typedef logic [PIX_W-1:0]     t_pix;
    typedef logic [LUMA_AW-1:0]   t_luma_addr;
    typedef logic [CHROMA_AW-1:0] t_chroma_addr;
    typedef logic [CIDX_W-1:0]    t_cidx;
    typedef logic [PLANE_W-1:0]   t_plane;
    typedef logic [CFG_DW-1:0]    t_cfg_data;
    typedef logic [CFG_IW-1:0]    t_cfg_index;

    // One item after the input register, handed to the result stage.
    typedef struct packed {
        t_luma_addr luma_addr;
        t_pix       luma_left;
        t_pix       luma_right;
        t_pix       blue;
        t_pix       red;
        logic       odd_row;
        logic       swap;
        logic       frame_end;
        t_cidx      cidx;
        t_plane     plane;
    } t_stage_a;

endpackage

// ===== sv/y2p_ifs.sv =====
// ----------------------------------------------------------------------------
// y2p channel interfaces
// Valid/ready channels for input macropixels, result items and register
// writes.
// ----------------------------------------------------------------------------

// Input channel: one packed YUYV macropixel per item.
interface y2p_in_if;
    logic          valid;
    logic          ready;
    y2p_pkg::t_pix luma_left;
    y2p_pkg::t_pix chroma_blue;
    y2p_pkg::t_pix luma_right;
    y2p_pkg::t_pix chroma_red;

    modport source (output valid, luma_left, chroma_blue, luma_right, chroma_red,
                    input ready);
    modport sink   (input valid, luma_left, chroma_blue, luma_right, chroma_red,
                    output ready);
endinterface

// Output channel: addressed luma and chroma writes for one macropixel.
interface y2p_out_if;
    logic                  valid;
    logic                  ready;
    y2p_pkg::t_luma_addr   luma_address;
    y2p_pkg::t_pix         luma_left_value;
    y2p_pkg::t_pix         luma_right_value;
    logic                  chroma_valid;
    y2p_pkg::t_chroma_addr blue_address;
    y2p_pkg::t_chroma_addr red_address;
    y2p_pkg::t_pix         blue_average;
    y2p_pkg::t_pix         red_average;
    logic                  frame_end;

    modport source (output valid, luma_address, luma_left_value, luma_right_value,
                           chroma_valid, blue_address, red_address, blue_average,
                           red_average, frame_end,
                    input ready);
    modport sink   (input valid, luma_address, luma_left_value, luma_right_value,
                          chroma_valid, blue_address, red_address, blue_average,
                          red_average, frame_end,
                    output ready);
endinterface

// Configuration write channel.
interface y2p_cfg_if;
    logic                valid;
    logic                ready;
    y2p_pkg::t_cfg_index index;
    y2p_pkg::t_cfg_data  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/yuyv_to_planar_yuv420.sv =====
// ----------------------------------------------------------------------------
// yuyv_to_planar_yuv420
// Packed YUYV 4:2:2 to planar YUV 4:2:0 converter producing addressed luma
// and vertically averaged chroma writes.
// ----------------------------------------------------------------------------
//  Channel   Direction  Item
//  i_pix     in         one macropixel: luma_left, chroma_blue, luma_right,
//                       chroma_red
//  o_res     out        luma pair with address, chroma averages with plane
//                       addresses (odd rows), frame end flag
//  i_cfg     in         register write: index, data (always ready)
//
//  One item per clock sustained while o_res is ready; each accepted item passes
//  through the input register and then the output register, with the line
//  buffer read in between. i_rst_n is synchronous and resets the counters,
//  the configuration registers and both stage valids; the line buffer is not
//  cleared. A stall on o_res backs up through both stages to i_pix.ready.
// ----------------------------------------------------------------------------
module yuyv_to_planar_yuv420 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    y2p_in_if.sink    i_pix,
    y2p_cfg_if.sink   i_cfg,
    y2p_out_if.source o_res
);

    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int AW    = $clog2(DEPTH);

    logic              a_valid;
    y2p_pkg::t_stage_a a_item;
    logic              take;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_addr;
    logic [15:0]       mem_wdata;
    logic [15:0]       mem_rdata;

    // Counters, configuration and input register.
    y2p_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DEPTH      (DEPTH),
        .AW         (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_pix       (i_pix),
        .i_take      (take),
        .o_a_valid   (a_valid),
        .o_a         (a_item),
        .o_mem_we    (mem_we),
        .o_mem_re    (mem_re),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata)
    );

    // Chroma line buffer.
    y2p_line_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_addr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_addr),
        .o_rdata (mem_rdata)
    );

    // Result stage.
    y2p_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_a_valid (a_valid),
        .i_a       (a_item),
        .i_rdata   (mem_rdata),
        .o_take    (take),
        .o_res     (o_res)
    );

endmodule

// ===== sv/y2p_line_store.sv =====
// ----------------------------------------------------------------------------
// y2p_line_store
// Chroma line buffer with separate write and read ports, holding U and V of
// the previous even row, with a registered read.
// ----------------------------------------------------------------------------
module y2p_line_store #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    // Write on even rows, read on odd rows; read data held until next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/y2p_ctrl.sv =====
// ----------------------------------------------------------------------------
// y2p_ctrl
// Configuration registers, raster counters, input register and line buffer
// access for each accepted macropixel.
// ----------------------------------------------------------------------------
module y2p_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int DEPTH      = MAX_WIDTH / 2,
    parameter int AW         = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    y2p_cfg_if.sink           i_cfg,
    y2p_in_if.sink            i_pix,
    input  logic              i_take,
    output logic              o_a_valid,
    output y2p_pkg::t_stage_a o_a,
    output logic              o_mem_we,
    output logic              o_mem_re,
    output logic [AW-1:0]     o_mem_addr,
    output logic [15:0]       o_mem_wdata
);

    localparam int WW        = $clog2(MAX_WIDTH + 1);
    localparam int HW        = $clog2(MAX_HEIGHT + 1);
    localparam int RW        = $clog2(MAX_HEIGHT);
    localparam int EWW       = (WW > y2p_pkg::CFG_DW) ? WW : y2p_pkg::CFG_DW;
    localparam int EHW       = (HW > y2p_pkg::CFG_DW) ? HW : y2p_pkg::CFG_DW;
    localparam int MAXW_EVEN = (MAX_WIDTH / 2) * 2;
    localparam int MAXH_EVEN = (MAX_HEIGHT / 2) * 2;

    // Configuration registers.
    y2p_pkg::t_cfg_data r_cfg_width;
    y2p_pkg::t_cfg_data r_cfg_height;
    logic               r_cfg_swap;

    // Raster state.
    logic [AW-1:0]       r_col;
    logic [AW-1:0]       n_col;
    logic [RW-1:0]       r_row;
    logic [RW-1:0]       n_row;
    y2p_pkg::t_luma_addr r_luma;
    y2p_pkg::t_luma_addr n_luma;
    y2p_pkg::t_cidx      r_cidx;
    y2p_pkg::t_cidx      n_cidx;
    logic                frame_end;

    // Input register.
    logic              r_a_valid;
    y2p_pkg::t_stage_a r_a;

    logic            accept;
    logic [EWW-1:0]  w_even;
    logic [EHW-1:0]  h_even;
    logic [EWW-1:0]  w_clamp;
    logic [EHW-1:0]  h_clamp;
    logic [WW-1:0]   w_eff;
    logic [HW-1:0]   h_eff;
    logic [WW-1:0]   half;
    logic [WW-1:0]   col_inc;
    logic [HW-1:0]   row_inc;
    logic [WW+HW-1:0] plane;

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = !r_a_valid || i_take;
    assign accept      = i_pix.valid && i_pix.ready;

    // Register writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= y2p_pkg::RST_FRAME_WIDTH;
            r_cfg_height <= y2p_pkg::RST_FRAME_HEIGHT;
            r_cfg_swap   <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                y2p_pkg::REG_FRAME_WIDTH:  r_cfg_width  <= i_cfg.data;
                y2p_pkg::REG_FRAME_HEIGHT: r_cfg_height <= i_cfg.data;
                y2p_pkg::REG_SWAP_CHROMA:  r_cfg_swap   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Effective frame size: even, at least 2, at most the even maximum.
    always_comb begin
        w_even = EWW'(r_cfg_width) & ~EWW'(1);
        h_even = EHW'(r_cfg_height) & ~EHW'(1);
        if (w_even < EWW'(2)) begin
            w_clamp = EWW'(2);
        end else if (w_even > EWW'(MAXW_EVEN)) begin
            w_clamp = EWW'(MAXW_EVEN);
        end else begin
            w_clamp = w_even;
        end
        if (h_even < EHW'(2)) begin
            h_clamp = EHW'(2);
        end else if (h_even > EHW'(MAXH_EVEN)) begin
            h_clamp = EHW'(MAXH_EVEN);
        end else begin
            h_clamp = h_even;
        end
        w_eff = WW'(w_clamp);
        h_eff = HW'(h_clamp);
        half  = w_eff >> 1;
        plane = (WW+HW)'(w_eff) * (WW+HW)'(h_eff);
    end

    // Next raster position after the current item.
    always_comb begin
        col_inc   = WW'(r_col) + WW'(1);
        row_inc   = HW'(r_row) + HW'(1);
        n_luma    = r_luma + y2p_pkg::t_luma_addr'(2);
        n_cidx    = r_row[0] ? r_cidx + y2p_pkg::t_cidx'(1) : r_cidx;
        n_col     = AW'(col_inc);
        n_row     = r_row;
        frame_end = 1'b0;
        if (col_inc >= half) begin
            n_col = '0;
            if (row_inc >= h_eff) begin
                frame_end = 1'b1;
                n_row     = '0;
                n_luma    = '0;
                n_cidx    = '0;
            end else begin
                n_row = RW'(row_inc);
            end
        end
    end

    // Counters and input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_luma    <= '0;
            r_cidx    <= '0;
            r_a_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col     <= n_col;
                r_row     <= n_row;
                r_luma    <= n_luma;
                r_cidx    <= n_cidx;
                r_a_valid <= 1'b1;
            end else if (i_take) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    // Payload of the input register; no reset needed.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a.luma_addr  <= r_luma;
            r_a.luma_left  <= i_pix.luma_left;
            r_a.luma_right <= i_pix.luma_right;
            r_a.blue       <= i_pix.chroma_blue;
            r_a.red        <= i_pix.chroma_red;
            r_a.odd_row    <= r_row[0];
            r_a.swap       <= r_cfg_swap;
            r_a.frame_end  <= frame_end;
            r_a.cidx       <= r_cidx;
            r_a.plane      <= y2p_pkg::t_plane'(plane);
        end
    end

    // One line buffer access per item: write on even rows, read on odd rows.
    assign o_mem_we    = accept && !r_row[0];
    assign o_mem_re    = accept && r_row[0];
    assign o_mem_addr  = r_col;
    assign o_mem_wdata = {i_pix.chroma_blue, i_pix.chroma_red};

    assign o_a_valid = r_a_valid;
    assign o_a       = r_a;

endmodule

// ===== sv/y2p_out.sv =====
// ----------------------------------------------------------------------------
// y2p_out
// Result stage: chroma averaging, plane address generation and the output
// register.
// ----------------------------------------------------------------------------
module y2p_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_a_valid,
    input  y2p_pkg::t_stage_a i_a,
    input  logic [15:0]       i_rdata,
    output logic              o_take,
    y2p_out_if.source         o_res
);

    logic r_valid;

    y2p_pkg::t_luma_addr   r_luma_addr;
    y2p_pkg::t_pix         r_luma_left;
    y2p_pkg::t_pix         r_luma_right;
    logic                  r_chroma_valid;
    y2p_pkg::t_chroma_addr r_blue_addr;
    y2p_pkg::t_chroma_addr r_red_addr;
    y2p_pkg::t_pix         r_blue_avg;
    y2p_pkg::t_pix         r_red_avg;
    logic                  r_frame_end;

    logic [y2p_pkg::PIX_W:0] blue_sum;
    logic [y2p_pkg::PIX_W:0] red_sum;
    y2p_pkg::t_chroma_addr   first_addr;
    y2p_pkg::t_chroma_addr   second_addr;
    y2p_pkg::t_chroma_addr   n_blue_addr;
    y2p_pkg::t_chroma_addr   n_red_addr;
    y2p_pkg::t_pix           n_blue_avg;
    y2p_pkg::t_pix           n_red_avg;

    assign o_take = !r_valid || o_res.ready;

    // Averages with the row above and addresses in the two chroma planes.
    always_comb begin
        blue_sum    = {1'b0, i_rdata[15:8]} + {1'b0, i_a.blue};
        red_sum     = {1'b0, i_rdata[7:0]} + {1'b0, i_a.red};
        first_addr  = y2p_pkg::t_chroma_addr'(i_a.plane
                      + y2p_pkg::t_plane'(i_a.cidx));
        second_addr = y2p_pkg::t_chroma_addr'(i_a.plane + (i_a.plane >> 2)
                      + y2p_pkg::t_plane'(i_a.cidx));
        n_blue_avg  = '0;
        n_red_avg   = '0;
        n_blue_addr = '0;
        n_red_addr  = '0;
        if (i_a.odd_row) begin
            n_blue_avg  = blue_sum[y2p_pkg::PIX_W:1];
            n_red_avg   = red_sum[y2p_pkg::PIX_W:1];
            n_blue_addr = i_a.swap ? second_addr : first_addr;
            n_red_addr  = i_a.swap ? first_addr : second_addr;
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_a_valid;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (o_take && i_a_valid) begin
            r_luma_addr    <= i_a.luma_addr;
            r_luma_left    <= i_a.luma_left;
            r_luma_right   <= i_a.luma_right;
            r_chroma_valid <= i_a.odd_row;
            r_blue_addr    <= n_blue_addr;
            r_red_addr     <= n_red_addr;
            r_blue_avg     <= n_blue_avg;
            r_red_avg      <= n_red_avg;
            r_frame_end    <= i_a.frame_end;
        end
    end

    assign o_res.valid            = r_valid;
    assign o_res.luma_address     = r_luma_addr;
    assign o_res.luma_left_value  = r_luma_left;
    assign o_res.luma_right_value = r_luma_right;
    assign o_res.chroma_valid     = r_chroma_valid;
    assign o_res.blue_address     = r_blue_addr;
    assign o_res.red_address      = r_red_addr;
    assign o_res.blue_average     = r_blue_avg;
    assign o_res.red_average      = r_red_avg;
    assign o_res.frame_end        = r_frame_end;

endmodule
